// File: rtl/damage_history_ring_top_defines.svh
// assertion macros for the damage history ring
`ifndef DAMAGE_HISTORY_RING_TOP_DEFINES_SVH
`define DAMAGE_HISTORY_RING_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define DHR_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dhr assertion failed");
`define DHR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dhr assertion failed");
`else
`define DHR_ASSERT_SAME(label, clk, rstn, ante, cons)
`define DHR_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/dhr_pkg.sv
`default_nettype none

package dhr_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned TAG_W   = 32;

    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    localparam logic STATUS_FULL_REDRAW = 1'b0;
    localparam logic STATUS_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic               kind;
        logic [TAG_W-1:0]   cur_owner;
        logic [TAG_W-1:0]   cur_revision;
        logic [TAG_W-1:0]   base_owner;
        logic [TAG_W-1:0]   base_revision;
        logic [COORD_W-1:0] rect_left;
        logic [COORD_W-1:0] rect_top;
        logic [COORD_W-1:0] rect_right;
        logic [COORD_W-1:0] rect_bottom;
        logic               whole_frame;
        logic               last_region;
    } in_word_t;

    typedef struct packed {
        logic               status;
        logic [COORD_W-1:0] box_left;
        logic [COORD_W-1:0] box_top;
        logic [COORD_W-1:0] box_right;
        logic [COORD_W-1:0] box_bottom;
    } out_word_t;

    typedef struct packed {
        logic [COORD_W-1:0] left;
        logic [COORD_W-1:0] top;
        logic [COORD_W-1:0] right;
        logic [COORD_W-1:0] bottom;
    } box_t;

    typedef struct packed {
        logic [TAG_W-1:0] owner;
        logic [TAG_W-1:0] revision;
    } tag_t;

    typedef struct packed {
        tag_t before_tag;
        tag_t after_tag;
        logic full;
        box_t box;
    } entry_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADDR,
        ST_EVAL,
        ST_FIN
    } state_t;

    function automatic logic box_empty(input box_t b);
        return (b.left >= b.right) || (b.top >= b.bottom);
    endfunction

    function automatic box_t box_merge(input box_t acc, input box_t add);
        box_t res;
        res = acc;
        if (!box_empty(add)) begin
            if (box_empty(acc)) begin
                res = add;
            end else begin
                if (add.left < acc.left) begin
                    res.left = add.left;
                end
                if (add.top < acc.top) begin
                    res.top = add.top;
                end
                if (add.right > acc.right) begin
                    res.right = add.right;
                end
                if (add.bottom > acc.bottom) begin
                    res.bottom = add.bottom;
                end
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: rtl/damage_history_ring_top.sv
// damage history ring: keeps the last HISTORY_DEPTH content changes and answers
// coverage queries against them.
// input channel s_valid/s_ready/s_data carries one word per record rectangle or query.
// a record word gives no result; the word marked last commits the merged box with its
// before/after tags into the next ring slot, if its revision is nonzero and its tag
// differs from the newest one. a query word with a valid base makes the sequencer walk
// the ring from the oldest entry, one entry at a time through the single read port of
// the entry memory, an address state then an evaluate state per entry; the result word
// then sits in the output register on m_valid/m_data until m_ready takes it.
// s_ready is low while a query is in progress; when the receiver stalls, a finished
// query holds in the sequencer until the output register is free.
// reset (aresetn low at a clock edge) empties the ring and the pending box and
// invalidates the newest tag; no clearing pass is needed.
`default_nettype none

`include "damage_history_ring_top_defines.svh"

module damage_history_ring_top #(
    parameter int HISTORY_DEPTH = 8,
    parameter int COORD_BITS    = 16
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire dhr_pkg::in_word_t s_data,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output dhr_pkg::out_word_t    m_data
);

    localparam int SLOT_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int PW     = CNT_W + 1;
    localparam logic [dhr_pkg::COORD_W-1:0] COORD_MASK =
        (COORD_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << COORD_BITS) - 32'd1);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(HISTORY_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(HISTORY_DEPTH);

    dhr_pkg::entry_t mem [HISTORY_DEPTH];
    dhr_pkg::entry_t rd_data_reg;

    dhr_pkg::state_t state_reg, state_next;
    logic [SLOT_W-1:0] write_slot_reg, write_slot_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    dhr_pkg::tag_t     newest_reg, newest_next;
    dhr_pkg::box_t     pending_reg, pending_next;
    logic              m_valid_reg, m_valid_next;
    dhr_pkg::out_word_t m_data_reg, m_data_next;

    dhr_pkg::tag_t     chain_reg, chain_next;
    dhr_pkg::tag_t     cur_reg, cur_next;
    dhr_pkg::box_t     acc_reg, acc_next;
    logic              ok_reg, ok_next;
    logic [SLOT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0]  idx_reg, idx_next;

    logic              s_fire;
    logic              rd_en;
    logic              wr_en;
    logic              walk_done;
    logic              out_free;
    logic              base_ok;
    dhr_pkg::box_t     rect;
    dhr_pkg::box_t     merged;
    dhr_pkg::tag_t     in_cur;
    dhr_pkg::tag_t     in_base;
    dhr_pkg::entry_t   wr_entry;
    logic [PW-1:0]     ws_ext;
    logic [PW-1:0]     cnt_ext;
    logic [PW-1:0]     start_wide;

    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    assign rect.left   = s_data.rect_left & COORD_MASK;
    assign rect.top    = s_data.rect_top & COORD_MASK;
    assign rect.right  = s_data.rect_right & COORD_MASK;
    assign rect.bottom = s_data.rect_bottom & COORD_MASK;
    assign merged      = dhr_pkg::box_merge(pending_reg, rect);

    assign in_cur.owner     = s_data.cur_owner;
    assign in_cur.revision  = s_data.cur_revision;
    assign in_base.owner    = s_data.base_owner;
    assign in_base.revision = s_data.base_revision;
    assign base_ok = (s_data.base_revision != '0) && (s_data.base_owner == s_data.cur_owner);

    assign wr_entry.before_tag = in_base;
    assign wr_entry.after_tag  = in_cur;
    assign wr_entry.full       = s_data.whole_frame;
    assign wr_entry.box        = merged;

    // oldest slot of the ring
    assign ws_ext     = PW'(write_slot_reg);
    assign cnt_ext    = PW'(count_reg);
    assign start_wide = (ws_ext >= cnt_ext) ? (ws_ext - cnt_ext)
                                            : (ws_ext + PW'(HISTORY_DEPTH) - cnt_ext);

    assign walk_done = (idx_reg == count_reg) || (chain_reg == cur_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            dhr_pkg::ST_IDLE: begin
                if (s_fire && s_data.kind == dhr_pkg::KIND_QUERY) begin
                    state_next = base_ok ? dhr_pkg::ST_ADDR : dhr_pkg::ST_FIN;
                end
            end
            dhr_pkg::ST_ADDR: begin
                state_next = walk_done ? dhr_pkg::ST_FIN : dhr_pkg::ST_EVAL;
            end
            dhr_pkg::ST_EVAL: begin
                if (rd_data_reg.before_tag == chain_reg && rd_data_reg.full) begin
                    state_next = dhr_pkg::ST_FIN;
                end else begin
                    state_next = dhr_pkg::ST_ADDR;
                end
            end
            dhr_pkg::ST_FIN: begin
                if (out_free) begin
                    state_next = dhr_pkg::ST_IDLE;
                end
            end
            default: state_next = dhr_pkg::ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        s_ready = 1'b0;
        rd_en   = 1'b0;
        wr_en   = 1'b0;
        case (state_reg)
            dhr_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                wr_en   = s_fire && s_data.kind == dhr_pkg::KIND_RECORD && s_data.last_region
                          && s_data.cur_revision != '0 && in_cur != newest_reg;
            end
            dhr_pkg::ST_ADDR: rd_en = !walk_done;
            dhr_pkg::ST_EVAL: rd_en = 1'b0;
            dhr_pkg::ST_FIN:  rd_en = 1'b0;
            default:          rd_en = 1'b0;
        endcase
    end

    // datapath
    always_comb begin
        write_slot_next = write_slot_reg;
        count_next      = count_reg;
        newest_next     = newest_reg;
        pending_next    = pending_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        chain_next      = chain_reg;
        cur_next        = cur_reg;
        acc_next        = acc_reg;
        ok_next         = ok_reg;
        ptr_next        = ptr_reg;
        idx_next        = idx_reg;
        case (state_reg)
            dhr_pkg::ST_IDLE: begin
                if (s_fire && s_data.kind == dhr_pkg::KIND_RECORD) begin
                    if (s_data.last_region) begin
                        pending_next = '0;
                        if (wr_en) begin
                            write_slot_next = (write_slot_reg == LAST_SLOT) ? '0
                                              : write_slot_reg + SLOT_W'(1);
                            if (count_reg != FULL_CNT) begin
                                count_next = count_reg + CNT_W'(1);
                            end
                            newest_next = in_cur;
                        end
                    end else begin
                        pending_next = merged;
                    end
                end else if (s_fire) begin
                    chain_next = in_base;
                    cur_next   = in_cur;
                    acc_next   = '0;
                    ok_next    = base_ok;
                    ptr_next   = start_wide[SLOT_W-1:0];
                    idx_next   = '0;
                end
            end
            dhr_pkg::ST_ADDR: begin
                if (walk_done) begin
                    ok_next = ok_reg && (chain_reg == cur_reg);
                end
            end
            dhr_pkg::ST_EVAL: begin
                if (rd_data_reg.before_tag == chain_reg) begin
                    if (rd_data_reg.full) begin
                        ok_next = 1'b0;
                    end else begin
                        acc_next   = dhr_pkg::box_merge(acc_reg, rd_data_reg.box);
                        chain_next = rd_data_reg.after_tag;
                    end
                end
                idx_next = idx_reg + CNT_W'(1);
                ptr_next = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + SLOT_W'(1);
            end
            dhr_pkg::ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (ok_reg) begin
                        m_data_next.status     = dhr_pkg::STATUS_INCREMENTAL;
                        m_data_next.box_left   = acc_reg.left;
                        m_data_next.box_top    = acc_reg.top;
                        m_data_next.box_right  = acc_reg.right;
                        m_data_next.box_bottom = acc_reg.bottom;
                    end else begin
                        m_data_next        = '0;
                        m_data_next.status = dhr_pkg::STATUS_FULL_REDRAW;
                    end
                end
            end
            default: begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= dhr_pkg::ST_IDLE;
            write_slot_reg <= '0;
            count_reg      <= '0;
            newest_reg     <= '0;
            pending_reg    <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            write_slot_reg <= write_slot_next;
            count_reg      <= count_next;
            newest_reg     <= newest_next;
            pending_reg    <= pending_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        chain_reg  <= chain_next;
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        ok_reg     <= ok_next;
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
    end

    // entry memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[write_slot_reg] <= wr_entry;
        end
        if (rd_en) begin
            rd_data_reg <= mem[ptr_reg];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `DHR_ASSERT_SAME(a_count_bound, aclk, aresetn, 1'b1, count_reg <= FULL_CNT)
    `DHR_ASSERT_SAME(a_walk_bound, aclk, aresetn, state_reg == dhr_pkg::ST_EVAL, idx_reg < count_reg)
    `DHR_ASSERT_NEXT(a_query_busy, aclk, aresetn, s_fire && s_data.kind == dhr_pkg::KIND_QUERY, !s_ready)

endmodule

`default_nettype wire
